FILE: design/apc_pkg.sv
// Shared constants for the action potential characterizer.
// No dependencies; used by apc_track and action_potential_characterizer.
`timescale 1ns / 1ps
`default_nettype none

package apc_pkg;

    localparam int VOLT_BITS_DEF  = 16;
    localparam int SLOPE_BITS_DEF = 24;
    localparam int TIME_BITS_DEF  = 32;

    // The interval output never carries more than this many bits.
    localparam int IVL_MAX_BITS = 32;

endpackage

`default_nettype wire

FILE: design/action_potential_characterizer.sv
// Top level of the action potential characterizer.
// Instantiates apc_in_reg and apc_track; uses apc_pkg for defaults.
`timescale 1ns / 1ps
`default_nettype none

// One sample beat is taken per clock while o_in_stall is low, and one result
// beat, carrying all five measures, comes out for each. A sample is held in
// the input register and then in the phase tracker, whose measure registers
// are the result register. Throughput is one beat per cycle while the output
// does not stall; the extremum test and phase update against the tracker
// state are combinational. Stall on the output holds the result; the input
// register still takes a beat if it is empty, and then stalls the source.

module action_potential_characterizer #(
    parameter int VOLT_BITS  = apc_pkg::VOLT_BITS_DEF,
    parameter int SLOPE_BITS = apc_pkg::SLOPE_BITS_DEF,
    parameter int TIME_BITS  = apc_pkg::TIME_BITS_DEF,
    parameter int IVL_BITS   = (TIME_BITS < apc_pkg::IVL_MAX_BITS) ? TIME_BITS
                                                                   : apc_pkg::IVL_MAX_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic signed [VOLT_BITS-1:0]  i_voltage,
    input  wire logic signed [SLOPE_BITS-1:0] i_slope,
    input  wire logic                         i_stim_negative,
    input  wire logic [TIME_BITS-1:0]         i_timestamp,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic signed [VOLT_BITS-1:0]       o_rest_level,
    output logic signed [VOLT_BITS-1:0]       o_peak_level,
    output logic signed [VOLT_BITS:0]         o_peak_to_trough,
    output logic signed [VOLT_BITS:0]         o_trough_to_next,
    output logic [IVL_BITS-1:0]               o_trough_interval
);

    logic                         w_advance;
    logic                         w_s_valid;
    logic signed [VOLT_BITS-1:0]  w_s_voltage;
    logic signed [SLOPE_BITS-1:0] w_s_slope;
    logic                         w_s_stim;
    logic [TIME_BITS-1:0]         w_s_time;
    logic                         r_out_valid;

    // The result stage may load whenever it is empty or its beat is taken.
    assign w_advance = !r_out_valid || !i_out_stall;

    apc_in_reg #(
        .VOLT_BITS  (VOLT_BITS),
        .SLOPE_BITS (SLOPE_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_in_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_voltage       (i_voltage),
        .i_slope         (i_slope),
        .i_stim_negative (i_stim_negative),
        .i_timestamp     (i_timestamp),
        .i_advance       (w_advance),
        .o_valid         (w_s_valid),
        .o_voltage       (w_s_voltage),
        .o_slope         (w_s_slope),
        .o_stim_negative (w_s_stim),
        .o_timestamp     (w_s_time)
    );

    apc_track #(
        .VOLT_BITS  (VOLT_BITS),
        .SLOPE_BITS (SLOPE_BITS),
        .TIME_BITS  (TIME_BITS),
        .IVL_BITS   (IVL_BITS)
    ) u_track (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (w_s_valid && w_advance),
        .i_voltage         (w_s_voltage),
        .i_slope           (w_s_slope),
        .i_stim_negative   (w_s_stim),
        .i_timestamp       (w_s_time),
        .o_rest_level      (o_rest_level),
        .o_peak_level      (o_peak_level),
        .o_peak_to_trough  (o_peak_to_trough),
        .o_trough_to_next  (o_trough_to_next),
        .o_trough_interval (o_trough_interval)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_s_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: design/apc_in_reg.sv
// Input register stage of the action potential characterizer.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module apc_in_reg #(
    parameter int VOLT_BITS  = 16,
    parameter int SLOPE_BITS = 24,
    parameter int TIME_BITS  = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic signed [VOLT_BITS-1:0]  i_voltage,
    input  wire logic signed [SLOPE_BITS-1:0] i_slope,
    input  wire logic                         i_stim_negative,
    input  wire logic [TIME_BITS-1:0]         i_timestamp,
    input  wire logic                         i_advance,
    output logic                              o_valid,
    output logic signed [VOLT_BITS-1:0]       o_voltage,
    output logic signed [SLOPE_BITS-1:0]      o_slope,
    output logic                              o_stim_negative,
    output logic [TIME_BITS-1:0]              o_timestamp
);

    logic                         r_valid;
    logic signed [VOLT_BITS-1:0]  r_voltage;
    logic signed [SLOPE_BITS-1:0] r_slope;
    logic                         r_stim_negative;
    logic [TIME_BITS-1:0]         r_timestamp;

    // The held beat can only leave when the next stage moves.
    assign o_in_stall = r_valid && !i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_voltage       <= i_voltage;
            r_slope         <= i_slope;
            r_stim_negative <= i_stim_negative;
            r_timestamp     <= i_timestamp;
        end
    end

    assign o_valid         = r_valid;
    assign o_voltage       = r_voltage;
    assign o_slope         = r_slope;
    assign o_stim_negative = r_stim_negative;
    assign o_timestamp     = r_timestamp;

endmodule

`default_nettype wire

FILE: design/apc_track.sv
// Phase tracker and measure registers of the action potential characterizer.
// Uses apc_pkg for the interval width limit.
`timescale 1ns / 1ps
`default_nettype none

module apc_track #(
    parameter int VOLT_BITS  = 16,
    parameter int SLOPE_BITS = 24,
    parameter int TIME_BITS  = 32,
    parameter int IVL_BITS   = (TIME_BITS < apc_pkg::IVL_MAX_BITS) ? TIME_BITS
                                                                   : apc_pkg::IVL_MAX_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_step,
    input  wire logic signed [VOLT_BITS-1:0]  i_voltage,
    input  wire logic signed [SLOPE_BITS-1:0] i_slope,
    input  wire logic                         i_stim_negative,
    input  wire logic [TIME_BITS-1:0]         i_timestamp,
    output logic signed [VOLT_BITS-1:0]       o_rest_level,
    output logic signed [VOLT_BITS-1:0]       o_peak_level,
    output logic signed [VOLT_BITS:0]         o_peak_to_trough,
    output logic signed [VOLT_BITS:0]         o_trough_to_next,
    output logic [IVL_BITS-1:0]               o_trough_interval
);

    typedef enum logic [1:0] {
        PH_PEAK   = 2'd0,
        PH_TROUGH = 2'd1,
        PH_RISE   = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    t_phase                      r_phase, n_phase, w_phase_in;
    logic                        r_stim_active;
    logic                        r_ps_zero, r_ps_neg;
    logic signed [VOLT_BITS-1:0] r_prev_voltage;
    logic signed [VOLT_BITS-1:0] r_rest, n_rest;
    logic signed [VOLT_BITS-1:0] r_peak, n_peak;
    logic signed [VOLT_BITS:0]   r_drop, n_drop;
    logic signed [VOLT_BITS:0]   r_rise, n_rise;
    logic signed [VOLT_BITS-1:0] r_trough_v, n_trough_v;
    logic [TIME_BITS-1:0]        r_trough_t, n_trough_t;
    logic [IVL_BITS-1:0]         r_interval, n_interval;
    logic [TIME_BITS-1:0]        w_elapsed;
    logic                        w_onset, w_s_zero, w_s_neg, w_extremum;

    assign w_onset    = i_stim_negative && !r_stim_active;
    assign w_s_zero   = (i_slope == '0);
    assign w_s_neg    = i_slope[SLOPE_BITS-1];
    // An extremum is any sample whose slope is not of strictly the same sign as the last.
    assign w_extremum = w_s_zero || r_ps_zero || (w_s_neg != r_ps_neg);
    assign w_phase_in = w_onset ? PH_PEAK : r_phase;
    assign w_elapsed  = i_timestamp - r_trough_t;

    always_comb begin
        n_phase    = w_phase_in;
        n_rest     = w_onset ? r_prev_voltage : r_rest;
        n_peak     = r_peak;
        n_drop     = r_drop;
        n_rise     = r_rise;
        n_trough_v = r_trough_v;
        n_trough_t = r_trough_t;
        n_interval = r_interval;
        if (w_extremum) begin
            unique case (w_phase_in)
                PH_PEAK: begin
                    if (w_s_neg) begin
                        n_peak  = i_voltage;
                        n_phase = PH_TROUGH;
                    end
                end
                PH_TROUGH: begin
                    n_drop     = {r_peak[VOLT_BITS-1], r_peak}
                               - {i_voltage[VOLT_BITS-1], i_voltage};
                    n_trough_v = i_voltage;
                    n_trough_t = i_timestamp;
                    n_phase    = PH_RISE;
                end
                PH_RISE: begin
                    n_rise     = {i_voltage[VOLT_BITS-1], i_voltage}
                               - {r_trough_v[VOLT_BITS-1], r_trough_v};
                    n_interval = w_elapsed[IVL_BITS-1:0];
                    n_phase    = PH_DONE;
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_TROUGH;
            r_stim_active  <= 1'b0;
            r_ps_zero      <= 1'b1;
            r_ps_neg       <= 1'b0;
            r_prev_voltage <= '0;
            r_rest         <= '0;
            r_peak         <= '0;
            r_drop         <= '0;
            r_rise         <= '0;
            r_trough_v     <= '0;
            r_trough_t     <= '0;
            r_interval     <= '0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_stim_active  <= i_stim_negative;
            r_ps_zero      <= w_s_zero;
            r_ps_neg       <= w_s_neg;
            r_prev_voltage <= i_voltage;
            r_rest         <= n_rest;
            r_peak         <= n_peak;
            r_drop         <= n_drop;
            r_rise         <= n_rise;
            r_trough_v     <= n_trough_v;
            r_trough_t     <= n_trough_t;
            r_interval     <= n_interval;
        end
    end

    assign o_rest_level      = r_rest;
    assign o_peak_level      = r_peak;
    assign o_peak_to_trough  = r_drop;
    assign o_trough_to_next  = r_rise;
    assign o_trough_interval = r_interval;

endmodule

`default_nettype wire
